[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker file salru_checker.sv.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define SALRU_ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("salru check failed");

// Same, on the usual clk_i / rst_ni pair.
`define SALRU_ASSERT(lbl, prop) `SALRU_ASSERT_CLK(lbl, clk_i, rst_ni, prop)

`endif

[rtl/core/salru_pkg.sv]
// ----------------------------------------------------------------------------
// salru_pkg
// Types, codes and helpers of the set-associative LRU cache directory.
// ----------------------------------------------------------------------------
package salru_pkg;

  localparam int ADDR_W  = 64;
  localparam int TAG_W   = 62;  // block and set fields take at least two bits
  localparam int TOT_W   = 32;
  localparam int CFG_W   = 5;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_STORE  = 2'd1,
    CMD_MODIFY = 2'd2,
    CMD_NONE   = 2'd3
  } salru_cmd_e;

  typedef enum logic [1:0] {
    REG_SET_BITS   = 2'd0,
    REG_BLOCK_BITS = 2'd1,
    REG_WAYS       = 2'd2
  } salru_reg_e;

  typedef struct packed {
    logic [1:0]        command;
    logic [ADDR_W-1:0] address;
  } salru_in_t;

  typedef struct packed {
    logic             hit;
    logic             miss;
    logic             eviction;
    logic             last;
    logic [TOT_W-1:0] hit_total;
    logic [TOT_W-1:0] miss_total;
    logic [TOT_W-1:0] evict_total;
  } salru_out_t;

  typedef struct packed {
    logic [1:0]       index;
    logic [CFG_W-1:0] value;
  } salru_cfg_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;   // capture input beat, start row read
    logic reread;   // read stored set again for second access
    logic commit;   // write row back, update totals, load result
    logic last;     // result closes the item
  } salru_ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic in_void;  // incoming command produces nothing
    logic modify;   // captured command makes two accesses
  } salru_sts_t;

  function automatic logic [TOT_W-1:0] sat_inc(input logic [TOT_W-1:0] v);
    return (v == '1) ? v : v + TOT_W'(1);
  endfunction

endpackage

[rtl/core/salru_stream_if.sv]
// ----------------------------------------------------------------------------
// salru_stream_if
// Valid/ready channel carrying one payload struct per beat.
// ----------------------------------------------------------------------------
interface salru_stream_if #(
  parameter type data_t = logic
);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/salru_ram.sv]
// ----------------------------------------------------------------------------
// salru_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module salru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/salru_ctrl.sv]
// ----------------------------------------------------------------------------
// salru_ctrl
// Sequencer: accept, look up, write back; a modify loops for a second access.
// ----------------------------------------------------------------------------
module salru_ctrl import salru_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  salru_sts_t sts_i,
  output salru_ctl_t ctl_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_LOOK = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   second_q, second_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    ctl_o.accept = (state_q == S_IDLE) && in_valid_i;
    ctl_o.reread = (state_q == S_READ);
    ctl_o.commit = (state_q == S_LOOK) && out_free;
    ctl_o.last   = !(sts_i.modify && !second_q);
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d  = state_q;
    second_d = second_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && !sts_i.in_void) begin
          state_d  = S_LOOK;
          second_d = 1'b0;
        end
      end
      S_READ: begin
        state_d = S_LOOK;
      end
      S_LOOK: begin
        if (ctl_o.commit) begin
          if (ctl_o.last) begin
            state_d = S_IDLE;
          end else begin
            state_d  = S_READ;
            second_d = 1'b1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctl_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      second_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      second_q    <= second_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

[rtl/core/salru_dp.sv]
// ----------------------------------------------------------------------------
// salru_dp
// Datapath: geometry registers, set row RAM, hit / victim / age logic, totals.
// ----------------------------------------------------------------------------
module salru_dp import salru_pkg::*; #(
  parameter int MAX_SETS = 64,
  parameter int MAX_WAYS = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  salru_cfg_t cfg_data_i,
  input  salru_in_t  in_data_i,
  input  salru_ctl_t ctl_i,
  output salru_sts_t sts_o,
  output salru_out_t out_data_o
);

  // Set index width: floor(log2(MAX_SETS)) capped at six bits.
  localparam int SET_FL = $clog2(MAX_SETS + 1) - 1;
  localparam int SET_W  = (SET_FL > 6) ? 6 : SET_FL;
  localparam int ROWS   = 1 << SET_W;
  localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int RANK_W = WAY_W;
  localparam int EW     = $clog2(MAX_WAYS + 1);

  typedef struct packed {
    logic              valid;
    logic [TAG_W-1:0]  tag;
    logic [RANK_W-1:0] rank;
  } line_t;

  typedef line_t [MAX_WAYS-1:0] row_t;

  // geometry registers
  logic [2:0] set_bits_q;
  logic [4:0] block_bits_q;
  logic [3:0] ways_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_bits_q   <= 3'd1;
      block_bits_q <= 5'd1;
      ways_q       <= 4'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_data_i.index)
        REG_SET_BITS:   set_bits_q   <= cfg_data_i.value[2:0];
        REG_BLOCK_BITS: block_bits_q <= cfg_data_i.value[4:0];
        REG_WAYS:       ways_q       <= cfg_data_i.value[3:0];
        default: ;
      endcase
    end
  end

  // clamped geometry
  localparam logic [2:0] SET_LIM = 3'(SET_W);
  logic [2:0]    s_eff;
  logic [4:0]    b_eff;
  logic [4:0]    e_wide;
  logic [EW-1:0] e_eff;
  logic [5:0]    tag_sh;

  always_comb begin
    if (set_bits_q == 3'd0) begin
      s_eff = 3'd1;
    end else if (set_bits_q > SET_LIM) begin
      s_eff = SET_LIM;
    end else begin
      s_eff = set_bits_q;
    end
    b_eff = (block_bits_q == 5'd0) ? 5'd1 : block_bits_q;
    if (ways_q == 4'd0) begin
      e_wide = 5'd1;
    end else if ({1'b0, ways_q} > 5'(MAX_WAYS)) begin
      e_wide = 5'(MAX_WAYS);
    end else begin
      e_wide = {1'b0, ways_q};
    end
    e_eff  = EW'(e_wide);
    tag_sh = {1'b0, b_eff} + {3'b000, s_eff};
  end

  // field extraction of the incoming address
  logic [SET_W-1:0]  set_mask;
  logic [ADDR_W-1:0] addr_sh;
  logic [SET_W-1:0]  set_in;
  logic [ADDR_W-1:0] tag_full;

  assign set_mask = ~({SET_W{1'b1}} << s_eff);
  assign addr_sh  = in_data_i.address >> b_eff;
  assign set_in   = addr_sh[SET_W-1:0] & set_mask;
  assign tag_full = in_data_i.address >> tag_sh;

  logic [SET_W-1:0] set_q;
  logic [TAG_W-1:0] tag_q;
  logic             modify_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.accept) begin
      set_q    <= set_in;
      tag_q    <= tag_full[TAG_W-1:0];
      modify_q <= (in_data_i.command == CMD_MODIFY);
    end
  end

  assign sts_o.in_void = (in_data_i.command == CMD_NONE);
  assign sts_o.modify  = modify_q;

  // row storage; a row never written reads as all lines invalid
  logic [ROWS-1:0]  row_init_q;
  row_t             ram_rdata;
  row_t             row_cur;
  row_t             row_new;
  logic [SET_W-1:0] ram_raddr;

  assign ram_raddr = ctl_i.accept ? set_in : set_q;

  salru_ram #(
    .WIDTH ($bits(row_t)),
    .DEPTH (ROWS)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (ctl_i.commit),
    .waddr_i (set_q),
    .wdata_i (row_new),
    .re_i    (ctl_i.accept || ctl_i.reread),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_init_q <= '0;
    end else if (ctl_i.commit) begin
      row_init_q[set_q] <= 1'b1;
    end
  end

  // lookup, victim choice and age update
  logic              hit;
  logic              found_inv;
  logic              evict;
  logic [WAY_W-1:0]  hit_way;
  logic [WAY_W-1:0]  inv_way;
  logic [WAY_W-1:0]  lru_way;
  logic [WAY_W-1:0]  victim;
  logic [RANK_W:0]   old_rank;

  always_comb begin
    row_cur   = row_init_q[set_q] ? ram_rdata : '0;
    hit       = 1'b0;
    hit_way   = '0;
    found_inv = 1'b0;
    inv_way   = '0;
    // descending scan leaves the lowest matching way
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (EW'(w) < e_eff) begin
        if (row_cur[w].valid && (row_cur[w].tag == tag_q)) begin
          hit     = 1'b1;
          hit_way = WAY_W'(w);
        end
        if (!row_cur[w].valid) begin
          found_inv = 1'b1;
          inv_way   = WAY_W'(w);
        end
      end
    end
    // oldest way in use, lowest index among equal ranks
    lru_way = '0;
    for (int w = 1; w < MAX_WAYS; w++) begin
      if ((EW'(w) < e_eff) && (row_cur[w].rank > row_cur[lru_way].rank)) begin
        lru_way = WAY_W'(w);
      end
    end
    if (hit) begin
      victim = hit_way;
    end else if (found_inv) begin
      victim = inv_way;
    end else begin
      victim = lru_way;
    end
    evict = !hit && !found_inv;

    old_rank = row_cur[victim].valid ? {1'b0, row_cur[victim].rank}
                                     : (RANK_W + 1)'(MAX_WAYS);
    row_new = row_cur;
    for (int j = 0; j < MAX_WAYS; j++) begin
      if ((WAY_W'(j) != victim) && row_cur[j].valid &&
          ({1'b0, row_cur[j].rank} < old_rank) &&
          (row_cur[j].rank < RANK_W'(MAX_WAYS - 1))) begin
        row_new[j].rank = row_cur[j].rank + RANK_W'(1);
      end
    end
    row_new[victim].valid = 1'b1;
    row_new[victim].tag   = tag_q;
    row_new[victim].rank  = '0;
  end

  // running totals and result register
  logic [TOT_W-1:0] hits_q, misses_q, evicts_q;
  logic [TOT_W-1:0] hits_d, misses_d, evicts_d;
  salru_out_t       out_q;

  always_comb begin
    hits_d   = hit   ? sat_inc(hits_q)   : hits_q;
    misses_d = !hit  ? sat_inc(misses_q) : misses_q;
    evicts_d = evict ? sat_inc(evicts_q) : evicts_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hits_q   <= '0;
      misses_q <= '0;
      evicts_q <= '0;
    end else if (ctl_i.commit) begin
      hits_q   <= hits_d;
      misses_q <= misses_d;
      evicts_q <= evicts_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.commit) begin
      out_q.hit         <= hit;
      out_q.miss        <= !hit;
      out_q.eviction    <= evict;
      out_q.last        <= ctl_i.last;
      out_q.hit_total   <= hits_d;
      out_q.miss_total  <= misses_d;
      out_q.evict_total <= evicts_d;
    end
  end

  assign out_data_o = out_q;

endmodule

[rtl/core/set_assoc_lru_cache_model.sv]
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_model
// Set-associative cache directory with LRU replacement and running totals.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_i  : register writes (set_bits, block_bits, ways_in_use), always ready;
//            write only while the block is idle.
//   in_i   : one access beat: command (load, store, modify) and address.
//            Command 3 is taken and produces nothing.
//   out_o  : one result per access; a modify gives two, the second with last.
// Timing: an access is an accept step (row RAM read), then lookup and
//   write-back of the set row; a modify adds a second read and lookup.
//   The result is registered and shows in the cycle after the lookup.
//   The set row RAM's registered read and per-access write-back pace accesses.
// in_i is ready only between items. A stalled result holds out_o and stops
//   the lookup of the next access until it is taken.
// Reset: every line invalid (per-row valid flags, no clearing pass), totals
//   zero, all three registers one.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_model import salru_pkg::*; #(
  parameter int MAX_SETS = 64,
  parameter int MAX_WAYS = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  salru_stream_if.sink   cfg_i,
  salru_stream_if.sink   in_i,
  salru_stream_if.source out_o
);

  salru_ctl_t ctl;
  salru_sts_t sts;

  assign cfg_i.ready = 1'b1;

  salru_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .ctl_o       (ctl)
  );

  salru_dp #(
    .MAX_SETS (MAX_SETS),
    .MAX_WAYS (MAX_WAYS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_i.valid),
    .cfg_data_i (cfg_i.data),
    .in_data_i  (in_i.data),
    .ctl_i      (ctl),
    .sts_o      (sts),
    .out_data_o (out_o.data)
  );

endmodule

[rtl/core/salru_checker.sv]
// ----------------------------------------------------------------------------
// salru_checker
// Port-level checks of the cache directory, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module salru_checker import salru_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input salru_out_t out_data_i
);

  // a stalled result beat stays put
  `SALRU_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))

  `SALRU_ASSERT(a_hit_xor_miss, out_valid_i |-> (out_data_i.hit != out_data_i.miss))

  `SALRU_ASSERT(a_evict_on_miss, out_valid_i && out_data_i.eviction |-> out_data_i.miss)

  // first half of a modify pending: the next item must not be taken yet
  `SALRU_ASSERT(a_pair_blocks_in, out_valid_i && !out_data_i.last |-> !(in_valid_i && in_ready_i))

endmodule

bind set_assoc_lru_cache_model salru_checker u_salru_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);

[bench/set_assoc_lru_cache_model_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_model_test
// Self-checking bench for the LRU cache directory. A behavioral copy of the
// directory predicts hit, miss, eviction, last and the running totals of each
// access when its input beat is taken. Each output beat is checked against the
// oldest prediction. Directed accesses come first, then register extremes,
// a long output stall, and random traffic under several geometries and
// idle patterns.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_model_test;
  import salru_pkg::*;

  localparam int SETS         = 64;
  localparam int WAYS         = 8;
  localparam int SET_BITS_MAX = ($clog2(SETS + 1) - 1 > 6) ? 6 : $clog2(SETS + 1) - 1;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 400000;

  logic clk_i;
  logic rst_ni;

  salru_stream_if #(.data_t(salru_cfg_t)) cfg_if ();
  salru_stream_if #(.data_t(salru_in_t))  in_if ();
  salru_stream_if #(.data_t(salru_out_t)) out_if ();

  set_assoc_lru_cache_model #(
    .MAX_SETS(SETS),
    .MAX_WAYS(WAYS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_if),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // directory copy
  logic              line_valid [SETS][WAYS];
  logic [63:0]       line_tag   [SETS][WAYS];
  logic [2:0]        line_rank  [SETS][WAYS];
  logic [TOT_W-1:0]  hit_count;
  logic [TOT_W-1:0]  miss_count;
  logic [TOT_W-1:0]  evict_count;
  logic [2:0]        cfg_set_bits;
  logic [4:0]        cfg_block_bits;
  logic [3:0]        cfg_ways;

  salru_out_t        pending_results[$];
  logic [63:0]       tag_pool[$];

  int                error_count;
  int                cycle_count;
  int                send_idle_pct;
  int                recv_idle_pct;
  int                hold_left;

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  function automatic int unsigned eff_set_bits();
    if (cfg_set_bits < 1) return 1;
    return (cfg_set_bits > SET_BITS_MAX) ? SET_BITS_MAX : cfg_set_bits;
  endfunction

  function automatic int unsigned eff_block_bits();
    return (cfg_block_bits < 1) ? 1 : cfg_block_bits;
  endfunction

  function automatic int unsigned eff_ways();
    if (cfg_ways < 1) return 1;
    return (cfg_ways > WAYS) ? WAYS : cfg_ways;
  endfunction

  // Make way w the most recent line of set st; lines more recent than it age by one.
  function automatic void promote_line(int unsigned st, int unsigned w);
    int unsigned old_rank;
    old_rank = line_valid[st][w] ? line_rank[st][w] : WAYS;
    for (int j = 0; j < WAYS; j++) begin
      if (j != w && line_valid[st][j] && line_rank[st][j] < old_rank) begin
        if (line_rank[st][j] < WAYS - 1) line_rank[st][j]++;
      end
    end
    line_rank[st][w] = '0;
  endfunction

  function automatic salru_out_t lookup_access(input logic [63:0] addr, input logic is_last);
    int unsigned s, b, e, st, hit_way, victim;
    logic [63:0] tag;
    logic        hit, evict, found_free;
    salru_out_t  r;
    s = eff_set_bits();
    b = eff_block_bits();
    e = eff_ways();
    st = int'((addr >> b) & ((64'd1 << s) - 64'd1));
    if (st >= SETS) st = 0;
    tag = addr >> (b + s);
    hit = 1'b0;
    evict = 1'b0;
    found_free = 1'b0;
    hit_way = 0;
    for (int w = 0; w < e; w++) begin
      if (!hit && line_valid[st][w] && line_tag[st][w] == tag) begin
        hit = 1'b1;
        hit_way = w;
      end
    end
    if (hit) begin
      promote_line(st, hit_way);
      if (hit_count != '1) hit_count++;
    end else begin
      if (miss_count != '1) miss_count++;
      victim = 0;
      for (int w = 0; w < e; w++) begin
        if (!found_free && !line_valid[st][w]) begin
          victim = w;
          found_free = 1'b1;
        end
      end
      // all ways in use are valid: oldest rank, lowest way on ties
      if (!found_free) begin
        for (int w = 1; w < e; w++) begin
          if (line_rank[st][w] > line_rank[st][victim]) victim = w;
        end
        evict = 1'b1;
        if (evict_count != '1) evict_count++;
      end
      promote_line(st, victim);
      line_valid[st][victim] = 1'b1;
      line_tag[st][victim] = tag;
    end
    r.hit = hit;
    r.miss = !hit;
    r.eviction = evict;
    r.last = is_last;
    r.hit_total = hit_count;
    r.miss_total = miss_count;
    r.evict_total = evict_count;
    return r;
  endfunction

  function automatic void predict_item(input salru_cmd_e cmd, input logic [63:0] addr);
    case (cmd)
      CMD_LOAD, CMD_STORE: begin
        pending_results.push_back(lookup_access(addr, 1'b1));
      end
      CMD_MODIFY: begin
        pending_results.push_back(lookup_access(addr, 1'b0));
        pending_results.push_back(lookup_access(addr, 1'b1));
      end
      default: begin
      end
    endcase
  endfunction

  function automatic logic [63:0] make_address(input logic [63:0] tag, input int unsigned st,
                                               input logic [63:0] offset);
    int unsigned s, b;
    s = eff_set_bits();
    b = eff_block_bits();
    return (tag << (b + s)) | ((64'(st) & ((64'd1 << s) - 64'd1)) << b)
           | (offset & ((64'd1 << b) - 64'd1));
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    error_count++;
    $display("[%0t] mismatch: %s expected %0h got %0h", $realtime, what, want, got);
  endtask

  // result checker
  always @(posedge clk_i) begin
    salru_out_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result beat with nothing pending", 64'd0, 64'(out_if.data));
      end else begin
        want = pending_results.pop_front();
        if (out_if.data.hit !== want.hit)
          report_mismatch("hit", want.hit, out_if.data.hit);
        if (out_if.data.miss !== want.miss)
          report_mismatch("miss", want.miss, out_if.data.miss);
        if (out_if.data.eviction !== want.eviction)
          report_mismatch("eviction", want.eviction, out_if.data.eviction);
        if (out_if.data.last !== want.last)
          report_mismatch("last", want.last, out_if.data.last);
        if (out_if.data.hit_total !== want.hit_total)
          report_mismatch("hit_total", want.hit_total, out_if.data.hit_total);
        if (out_if.data.miss_total !== want.miss_total)
          report_mismatch("miss_total", want.miss_total, out_if.data.miss_total);
        if (out_if.data.evict_total !== want.evict_total)
          report_mismatch("evict_total", want.evict_total, out_if.data.evict_total);
      end
    end
  end

  always @(negedge clk_i) begin
    out_if.ready = (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
  end

  // long output stall countdown
  always @(negedge clk_i) begin
    if (hold_left != 0) hold_left <= hold_left - 1;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_access(input salru_cmd_e cmd, input logic [63:0] addr);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid = 1'b0;
      @(negedge clk_i);
    end
    in_if.valid = 1'b1;
    in_if.data = '{command: cmd, address: addr};
    do @(posedge clk_i); while (!in_if.ready);
    predict_item(cmd, addr);
  endtask

  // Stop offering, let every pending result out, then allow for a void beat
  // still in flight.
  task automatic drain_results();
    @(negedge clk_i);
    in_if.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input salru_reg_e idx, input logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_if.valid = 1'b1;
    cfg_if.data = '{index: idx, value: val};
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      REG_SET_BITS:   cfg_set_bits = val[2:0];
      REG_BLOCK_BITS: cfg_block_bits = val[4:0];
      REG_WAYS:       cfg_ways = val[3:0];
      default: begin
      end
    endcase
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  task automatic configure_geometry(input logic [CFG_W-1:0] sb, input logic [CFG_W-1:0] bb,
                                    input logic [CFG_W-1:0] wy);
    drain_results();
    write_reg(REG_SET_BITS, sb);
    write_reg(REG_BLOCK_BITS, bb);
    write_reg(REG_WAYS, wy);
  endtask

  task automatic refill_tag_pool();
    int n;
    tag_pool.delete();
    n = eff_ways() + $urandom_range(0, 4);
    repeat (n) tag_pool.push_back({$urandom, $urandom});
  endtask

  task automatic send_random_items(input int count);
    int          pick;
    salru_cmd_e  cmd;
    logic [63:0] addr;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      cmd = (pick < 40) ? CMD_LOAD : (pick < 70) ? CMD_STORE :
            (pick < 95) ? CMD_MODIFY : CMD_NONE;
      if ($urandom_range(99) < 85)
        addr = make_address(tag_pool[$urandom_range(tag_pool.size() - 1)],
                            $urandom_range(3), {$urandom, $urandom});
      else
        addr = {$urandom, $urandom};
      send_access(cmd, addr);
    end
  endtask

  // Reset geometry: one set bit, one offset bit, direct mapped.
  task automatic test_reset_geometry();
    send_access(CMD_LOAD, 64'h0);
    send_access(CMD_LOAD, 64'h1);
    send_access(CMD_STORE, 64'hFFFF_FFFF_FFFF_FFFF);
    send_access(CMD_MODIFY, 64'h0);
    send_access(CMD_MODIFY, 64'h4);
    send_access(CMD_LOAD, 64'h0);
    send_access(CMD_NONE, 64'hFFFF_FFFF_FFFF_FFFF);
    send_access(CMD_STORE, 64'h8000_0000_0000_0002);
  endtask

  task automatic test_lru_order();
    configure_geometry(5'd2, 5'd3, 5'd4);
    for (int t = 1; t <= 4; t++) send_access(CMD_LOAD, make_address(64'(t), 1, 64'h5));
    send_access(CMD_LOAD, make_address(64'd1, 1, 64'h0));
    send_access(CMD_STORE, make_address(64'd5, 1, 64'h0));
    send_access(CMD_LOAD, make_address(64'd2, 1, 64'h7));
    send_access(CMD_MODIFY, make_address(64'd1, 1, 64'h0));
    // narrower associativity keeps old lines above the limit but ignores them
    configure_geometry(5'd2, 5'd3, 5'd2);
    send_access(CMD_LOAD, make_address(64'd4, 1, 64'h0));
    send_access(CMD_LOAD, make_address(64'd5, 1, 64'h0));
  endtask

  task automatic test_register_limits();
    configure_geometry(5'd7, 5'd0, 5'd0);
    send_access(CMD_LOAD, 64'hDEAD_BEEF_0123_4567);
    send_access(CMD_MODIFY, 64'hDEAD_BEEF_0123_4566);
    send_access(CMD_STORE, 64'h0123_4567_89AB_CDEF);
    configure_geometry(5'd0, 5'd31, 5'd15);
    send_access(CMD_LOAD, 64'hFFFF_FFFF_FFFF_FFFF);
    send_access(CMD_LOAD, 64'h0000_0001_0000_0000);
    send_access(CMD_MODIFY, 64'h7FFF_FFFF_FFFF_FFFF);
  endtask

  // Output held off while input keeps coming, so the block backs up.
  task automatic test_output_stall();
    configure_geometry(5'd3, 5'd2, 5'd8);
    refill_tag_pool();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    @(posedge clk_i);
    hold_left = HOLD_CYCLES;
    send_random_items(40);
  endtask

  task automatic test_random_traffic(input int send_pct, input int recv_pct, input int segments);
    int          pick;
    logic [CFG_W-1:0] bb;
    for (int seg = 0; seg < segments; seg++) begin
      pick = $urandom_range(99);
      bb = (pick < 70) ? CFG_W'($urandom_range(0, 6)) :
           (pick < 85) ? CFG_W'(31) : CFG_W'($urandom_range(0, 31));
      send_idle_pct = 0;
      recv_idle_pct = 0;
      configure_geometry(CFG_W'($urandom_range(0, 31)), bb, CFG_W'($urandom_range(0, 31)));
      refill_tag_pool();
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      send_random_items(42);
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    out_if.ready = 1'b0;
    error_count = 0;
    cycle_count = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_left = 0;
    foreach (line_valid[s, w]) begin
      line_valid[s][w] = 1'b0;
      line_tag[s][w] = '0;
      line_rank[s][w] = '0;
    end
    hit_count = '0;
    miss_count = '0;
    evict_count = '0;
    cfg_set_bits = 3'd1;
    cfg_block_bits = 5'd1;
    cfg_ways = 4'd1;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_geometry();
    test_lru_order();
    test_register_limits();
    test_output_stall();
    test_random_traffic(13, 85, 4);
    test_random_traffic(85, 13, 4);
    test_random_traffic(0, 0, 4);

    drain_results();
    repeat (20) @(posedge clk_i);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
